FILE: hw/rtl/rtb_pkg.sv
// Shared types, constants and helpers for the retransmit timer backoff core.
package rtb_pkg;

    // Action codes carried on the request channel
    localparam logic [2:0] ACT_RTO_DELAY   = 3'd0;
    localparam logic [2:0] ACT_PROBE_DELAY = 3'd1;
    localparam logic [2:0] ACT_HS_DELAY    = 3'd2;
    localparam logic [2:0] ACT_TIMEOUT     = 3'd3;
    localparam logic [2:0] ACT_ACK         = 3'd4;

    // Recovery mode codes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_HANDSHAKE = 3'd1;
    localparam logic [2:0] MODE_LOSS      = 3'd2;
    localparam logic [2:0] MODE_TAIL      = 3'd3;
    localparam logic [2:0] MODE_RTO       = 3'd4;

    localparam logic [25:0] MAX_DELAY_US     = 26'd60000000;
    localparam logic [34:0] RTO_NO_SAMPLE_US = 35'd500000;
    localparam logic [34:0] RTO_MIN_US       = 35'd200000;
    localparam logic [31:0] INITIAL_RTT_US   = 32'd333333;
    localparam logic [33:0] MULTI_PROBE_US   = 34'd10000;
    localparam logic [32:0] HS_NO_SAMPLE_US  = 33'd150000;
    localparam logic [32:0] HS_MIN_US        = 33'd10000;
    localparam logic [7:0]  MAX_RTO_SHIFT    = 8'd10;
    localparam logic [7:0]  MAX_HS_SHIFT     = 8'd8;
    localparam logic [7:0]  MAX_PROBES       = 8'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] srtt_us;
        logic [31:0] rtt_variance_us;
        logic [15:0] unacked_count;
        logic        handshake_unacked;
        logic        loss_scan_due;
    } item_t;

    typedef struct packed {
        logic [7:0] rto;
        logic [7:0] handshake;
        logic [7:0] probe;
    } counts_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       clear_loss;
    } event_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    function automatic logic [25:0] cap_delay(input logic [44:0] d);
        return (d > {19'd0, MAX_DELAY_US}) ? MAX_DELAY_US : d[25:0];
    endfunction

endpackage

FILE: hw/rtl/retransmit_timer_backoff_core.sv
// Top level of the retransmit timer backoff core.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | in_valid / in_ready  | action, srtt_us, rtt_variance_us,
//            |                      | unacked_count, handshake_unacked, loss_scan_due
//  result    | out_valid/out_ready  | delay_us, recovery_mode, clear_loss_scan
//  config    | cfg_valid/cfg_ready  | peer_ack_delay_max_us
//
// One request per cycle while the result side is not stalled; an accepted request waits in
// the request register and moves into the result register when the result side is free.
// The backoff counters update when a request moves into the result register.
// Reset clears both valid flags, the counters and the ack delay register.
// A stalled result holds the request register; ready drops only when both are full.
module retransmit_timer_backoff_core import rtb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] srtt_us,
    input  logic [31:0] rtt_variance_us,
    input  logic [15:0] unacked_count,
    input  logic        handshake_unacked,
    input  logic        loss_scan_due,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [25:0] delay_us,
    output logic [2:0]  recovery_mode,
    output logic        clear_loss_scan,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] peer_ack_delay_max_us
);

    item_t       item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [23:0] peer_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [25:0] delay_reg;
    logic [2:0]  mode_reg;
    logic        clr_reg;

    logic        advance;
    logic        fire;
    counts_t     counts;
    event_t      evt;
    logic [25:0] delay;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = item_valid_reg && advance;
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign item_valid_next = in_ready ? in_valid : item_valid_reg;
    assign out_valid_next  = advance ? item_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            peer_reg       <= 24'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                peer_reg <= peer_ack_delay_max_us;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action            <= action;
            item_reg.srtt_us           <= srtt_us;
            item_reg.rtt_variance_us   <= rtt_variance_us;
            item_reg.unacked_count     <= unacked_count;
            item_reg.handshake_unacked <= handshake_unacked;
            item_reg.loss_scan_due     <= loss_scan_due;
        end
        if (fire)
        begin
            delay_reg <= delay;
            mode_reg  <= evt.mode;
            clr_reg   <= evt.clear_loss;
        end
    end

    rtb_backoff_state u_state
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .counts (counts),
        .evt    (evt)
    );

    rtb_delay_calc u_delay
    (
        .item           (item_reg),
        .counts         (counts),
        .peer_ack_delay (peer_reg),
        .delay          (delay)
    );

    assign out_valid       = out_valid_reg;
    assign delay_us        = delay_reg;
    assign recovery_mode   = mode_reg;
    assign clear_loss_scan = clr_reg;

    // a result never carries both a delay and a recovery mode
    a_mode_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mode_reg == MODE_IDLE || delay_reg == 26'd0))
        else $error("recovery mode with nonzero delay");

    a_delay_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (delay_reg <= MAX_DELAY_US))
        else $error("delay above cap");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.action == ACT_ACK) |=>
            (counts.rto == 8'd0 && counts.handshake == 8'd0 && counts.probe == 8'd0))
        else $error("ack progress did not clear counters");

endmodule

FILE: hw/rtl/rtb_delay_calc.sv
// Delay arithmetic for the RTO, tail probe and handshake timers.
module rtb_delay_calc import rtb_pkg::*;
(
    input  item_t       item,
    input  counts_t     counts,
    input  logic [23:0] peer_ack_delay,
    output logic [25:0] delay
);

    logic [34:0] rto_sum;
    logic [34:0] rto_base;
    logic [3:0]  rto_shift;
    logic [44:0] rto_scaled;

    logic [31:0] probe_s;
    logic [33:0] probe_sum;
    logic [33:0] probe_base;
    logic [33:0] probe_floor;
    logic [33:0] probe_d;

    logic [32:0] hs_sum;
    logic [32:0] hs_base;
    logic [3:0]  hs_shift;
    logic [40:0] hs_scaled;

    always_comb
    begin
        // RTO: srtt + 4*var, floored, then backed off
        rto_sum = {3'd0, item.srtt_us} + {1'b0, item.rtt_variance_us, 2'b00};
        if (item.srtt_us == 32'd0)
        begin
            rto_base = RTO_NO_SAMPLE_US;
        end
        else if (rto_sum < RTO_MIN_US)
        begin
            rto_base = RTO_MIN_US;
        end
        else
        begin
            rto_base = rto_sum;
        end
        rto_shift  = (counts.rto > MAX_RTO_SHIFT) ? MAX_RTO_SHIFT[3:0] : counts.rto[3:0];
        rto_scaled = {10'd0, rto_base} << rto_shift;

        // Tail probe
        probe_s     = (item.srtt_us == 32'd0) ? INITIAL_RTT_US : item.srtt_us;
        probe_sum   = {2'd0, probe_s} + {3'd0, probe_s[31:1]} + {10'd0, peer_ack_delay};
        probe_base  = (item.unacked_count > 16'd1) ? MULTI_PROBE_US : probe_sum;
        probe_floor = {1'b0, probe_s, 1'b0};
        probe_d     = (probe_base < probe_floor) ? probe_floor : probe_base;

        // Handshake: 1.5*srtt, floored, then backed off
        hs_sum = {1'b0, item.srtt_us} + {2'd0, item.srtt_us[31:1]};
        if (item.srtt_us == 32'd0)
        begin
            hs_base = HS_NO_SAMPLE_US;
        end
        else if (hs_sum < HS_MIN_US)
        begin
            hs_base = HS_MIN_US;
        end
        else
        begin
            hs_base = hs_sum;
        end
        hs_shift  = (counts.handshake > MAX_HS_SHIFT) ? MAX_HS_SHIFT[3:0]
                                                      : counts.handshake[3:0];
        hs_scaled = {8'd0, hs_base} << hs_shift;

        case (item.action)
            ACT_RTO_DELAY:   delay = cap_delay(rto_scaled);
            ACT_PROBE_DELAY: delay = cap_delay({11'd0, probe_d});
            ACT_HS_DELAY:    delay = cap_delay({4'd0, hs_scaled});
            default:         delay = 26'd0;
        endcase
    end

endmodule

FILE: hw/rtl/rtb_backoff_state.sv
// Backoff counters and timeout / ack event handling.
module rtb_backoff_state import rtb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output counts_t counts,
    output event_t  evt
);

    logic [7:0] rto_count_reg;
    logic [7:0] rto_count_next;
    logic [7:0] hs_count_reg;
    logic [7:0] hs_count_next;
    logic [7:0] probe_count_reg;
    logic [7:0] probe_count_next;

    always_comb
    begin
        rto_count_next   = rto_count_reg;
        hs_count_next    = hs_count_reg;
        probe_count_next = probe_count_reg;
        evt.mode         = MODE_IDLE;
        evt.clear_loss   = 1'b0;

        case (item.action)
            ACT_HS_DELAY:
            begin
                // delay uses the old count, bump afterwards
                hs_count_next = sat_inc(hs_count_reg);
            end
            ACT_TIMEOUT:
            begin
                if (item.unacked_count == 16'd0)
                begin
                    evt.clear_loss = 1'b1;
                end
                else if (item.handshake_unacked)
                begin
                    evt.mode = MODE_HANDSHAKE;
                end
                else if (item.loss_scan_due)
                begin
                    evt.mode       = MODE_LOSS;
                    evt.clear_loss = 1'b1;
                end
                else if (probe_count_reg < MAX_PROBES)
                begin
                    evt.mode         = MODE_TAIL;
                    probe_count_next = sat_inc(probe_count_reg);
                end
                else
                begin
                    evt.mode       = MODE_RTO;
                    rto_count_next = sat_inc(rto_count_reg);
                end
            end
            ACT_ACK:
            begin
                rto_count_next   = 8'd0;
                hs_count_next    = 8'd0;
                probe_count_next = 8'd0;
                evt.clear_loss   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rto_count_reg   <= 8'd0;
            hs_count_reg    <= 8'd0;
            probe_count_reg <= 8'd0;
        end
        else if (fire)
        begin
            rto_count_reg   <= rto_count_next;
            hs_count_reg    <= hs_count_next;
            probe_count_reg <= probe_count_next;
        end
    end

    assign counts.rto       = rto_count_reg;
    assign counts.handshake = hs_count_reg;
    assign counts.probe     = probe_count_reg;

endmodule

FILE: tb/sv/rtb_scoreboard_pkg.sv
// Timer result predictor and scoreboard for the retransmit timer backoff core.
`timescale 1ns / 100ps

package rtb_scoreboard_pkg;
    import rtb_pkg::*;

    typedef struct packed {
        logic [25:0] delay_us;
        logic [2:0]  mode;
        logic        clear_loss;
    } timer_result_t;

    class timer_scoreboard;
        logic [23:0]   ack_delay_max;
        logic [7:0]    rto_backoff;
        logic [7:0]    hs_retries;
        logic [7:0]    probes;
        timer_result_t pending_results[$];
        int unsigned   mismatches;
        int unsigned   unexpected;
        int unsigned   checked;
        bit            rto_saturated;
        bit            hs_saturated;

        function new();
            ack_delay_max = '0;
            rto_backoff   = '0;
            hs_retries    = '0;
            probes        = '0;
            mismatches    = 0;
            unexpected    = 0;
            checked       = 0;
            rto_saturated = 0;
            hs_saturated  = 0;
        endfunction

        function void set_ack_delay(input logic [23:0] v);
            ack_delay_max = v;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function int unsigned failures();
            return mismatches + unexpected;
        endfunction

        function logic [25:0] clamp_delay(input logic [63:0] d);
            if (d > 64'(MAX_DELAY_US))
                return MAX_DELAY_US;
            return d[25:0];
        endfunction

        // Expected result of one request; advances the backoff counters.
        function timer_result_t compute_timer_result(input item_t req);
            timer_result_t res;
            logic [63:0]   srtt;
            logic [63:0]   rttvar;
            logic [63:0]   base;
            logic [63:0]   s;
            logic [63:0]   d;
            logic [7:0]    shift;
            res    = '0;
            srtt   = {32'd0, req.srtt_us};
            rttvar = {32'd0, req.rtt_variance_us};
            case (req.action)
                ACT_RTO_DELAY:
                begin
                    if (srtt == 0)
                        base = 64'(RTO_NO_SAMPLE_US);
                    else
                    begin
                        base = srtt + (rttvar << 2);
                        if (base < 64'(RTO_MIN_US))
                            base = 64'(RTO_MIN_US);
                    end
                    shift = (rto_backoff > MAX_RTO_SHIFT) ? MAX_RTO_SHIFT : rto_backoff;
                    res.delay_us = clamp_delay(base << shift);
                end
                ACT_PROBE_DELAY:
                begin
                    s = (srtt == 0) ? 64'(INITIAL_RTT_US) : srtt;
                    if (req.unacked_count > 16'd1)
                        d = 64'(MULTI_PROBE_US);
                    else
                        d = s + (s >> 1) + {40'd0, ack_delay_max};
                    if (d < (s << 1))
                        d = s << 1;
                    res.delay_us = clamp_delay(d);
                end
                ACT_HS_DELAY:
                begin
                    if (srtt == 0)
                        base = 64'(HS_NO_SAMPLE_US);
                    else
                    begin
                        base = srtt + (srtt >> 1);
                        if (base < 64'(HS_MIN_US))
                            base = 64'(HS_MIN_US);
                    end
                    shift = (hs_retries > MAX_HS_SHIFT) ? MAX_HS_SHIFT : hs_retries;
                    res.delay_us = clamp_delay(base << shift);
                    if (hs_retries != 8'hFF)
                        hs_retries = hs_retries + 8'd1;
                    else
                        hs_saturated = 1;
                end
                ACT_TIMEOUT:
                begin
                    // mode priority: nothing in flight, handshake, loss, tail probe, rto
                    if (req.unacked_count == 16'd0)
                        res.clear_loss = 1'b1;
                    else if (req.handshake_unacked)
                        res.mode = MODE_HANDSHAKE;
                    else if (req.loss_scan_due)
                    begin
                        res.mode       = MODE_LOSS;
                        res.clear_loss = 1'b1;
                    end
                    else if (probes < MAX_PROBES)
                    begin
                        res.mode = MODE_TAIL;
                        probes   = probes + 8'd1;
                    end
                    else
                    begin
                        res.mode = MODE_RTO;
                        if (rto_backoff != 8'hFF)
                            rto_backoff = rto_backoff + 8'd1;
                        else
                            rto_saturated = 1;
                    end
                end
                ACT_ACK:
                begin
                    rto_backoff    = '0;
                    hs_retries     = '0;
                    probes         = '0;
                    res.clear_loss = 1'b1;
                end
                default:
                begin
                end
            endcase
            return res;
        endfunction

        function void note_request(input item_t req);
            pending_results.push_back(compute_timer_result(req));
        endfunction

        function void check_result(input logic [25:0] delay_us, input logic [2:0] mode,
                                   input logic clear_loss);
            timer_result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (failures() <= 10)
                    $display("[%0t] result with no request outstanding: delay %0d mode %0d clr %0d",
                             $realtime, delay_us, mode, clear_loss);
                return;
            end
            want = pending_results.pop_front();
            if (want.delay_us !== delay_us || want.mode !== mode
                || want.clear_loss !== clear_loss)
            begin
                mismatches++;
                if (failures() <= 10)
                    $display("[%0t] result %0d: expected delay %0d mode %0d clr %0d, got %0d %0d %0d",
                             $realtime, checked, want.delay_us, want.mode, want.clear_loss,
                             delay_us, mode, clear_loss);
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/testbench.sv
// Top-level testbench for the retransmit timer backoff core.
`timescale 1ns / 100ps

module testbench;
    import rtb_pkg::*;
    import rtb_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    // codes outside the defined action set
    localparam logic [2:0]  ACT_SPARE_5 = 3'd5;
    localparam logic [2:0]  ACT_SPARE_6 = 3'd6;
    localparam logic [2:0]  ACT_SPARE_7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [31:0] srtt_us;
    logic [31:0] rtt_variance_us;
    logic [15:0] unacked_count;
    logic        handshake_unacked;
    logic        loss_scan_due;
    logic        out_valid;
    logic        out_ready;
    logic [25:0] delay_us;
    logic [2:0]  recovery_mode;
    logic        clear_loss_scan;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] peer_ack_delay_max_us;

    timer_scoreboard sb;
    int unsigned     sent;
    int unsigned     cfg_writes;
    int unsigned     cycle_count;
    bit              tx_quiet;
    bit              rx_quiet;
    bit              rx_hold;
    bit              hold_req;

    retransmit_timer_backoff_core DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .action                (action),
        .srtt_us               (srtt_us),
        .rtt_variance_us       (rtt_variance_us),
        .unacked_count         (unacked_count),
        .handshake_unacked     (handshake_unacked),
        .loss_scan_due         (loss_scan_due),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .delay_us              (delay_us),
        .recovery_mode         (recovery_mode),
        .clear_loss_scan       (clear_loss_scan),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .peer_ack_delay_max_us (peer_ack_delay_max_us)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold  = 1'b0;
            hold_req = 1'b0;
        end
    end

    // result side: random stalls, outputs checked at the rising edge
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_quiet ? 0 : $urandom_range(0, 8);
            if (stall != 0 || rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (rx_hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(delay_us, recovery_mode, clear_loss_scan);
        end
    end

    function automatic item_t mk_item(input logic [2:0] act, input logic [31:0] srtt,
                                      input logic [31:0] rttvar, input logic [15:0] unacked,
                                      input logic hs, input logic lp);
        item_t it;
        it.action            = act;
        it.srtt_us           = srtt;
        it.rtt_variance_us   = rttvar;
        it.unacked_count     = unacked;
        it.handshake_unacked = hs;
        it.loss_scan_due     = lp;
        return it;
    endfunction

    function automatic logic [31:0] rand_srtt();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(1, 20000);
            2, 3, 4: return $urandom_range(20000, 2000000);
            5:       return 32'hFFFF_FFFF;
            6, 7:    return $urandom;
            8:       return $urandom_range(1, 500);
            default: return $urandom_range(2000000, 40000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_rttvar();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1, 2:    return $urandom_range(0, 50000);
            3:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_unacked();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1, 2:    return 16'd1;
            3:       return 16'd2;
            4:       return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input item_t it);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action            <= it.action;
        srtt_us           <= it.srtt_us;
        rtt_variance_us   <= it.rtt_variance_us;
        unacked_count     <= it.unacked_count;
        handshake_unacked <= it.handshake_unacked;
        loss_scan_due     <= it.loss_scan_due;
        in_valid          <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(it);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_ack_delay(input logic [23:0] v);
        peer_ack_delay_max_us <= v;
        cfg_valid             <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_ack_delay(v);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one stretch of connection life: queries, timeouts, usually closed by an ack
    task automatic run_episode(input bit with_noise);
        item_t          it;
        logic [31:0]    srtt;
        int unsigned    len;
        int unsigned    r;
        srtt     = rand_srtt();
        len      = $urandom_range(2, 14);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (with_noise && $urandom_range(0, 5) == 0)
                it = mk_item(3'($urandom_range(0, 7)), $urandom, $urandom, 16'($urandom),
                             1'($urandom), 1'($urandom));
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    srtt = rand_srtt();
                r = $urandom_range(0, 99);
                if (r < 20)
                    it = mk_item(ACT_RTO_DELAY, srtt, rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom));
                else if (r < 35)
                    it = mk_item(ACT_PROBE_DELAY, srtt, rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom));
                else if (r < 45)
                    it = mk_item(ACT_HS_DELAY, srtt, rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom));
                else if (r < 90)
                    it = mk_item(ACT_TIMEOUT, srtt, rand_rttvar(),
                                 ($urandom_range(0, 9) == 0) ? 16'd0
                                     : 16'($urandom_range(1, 65535)),
                                 ($urandom_range(0, 6) == 0), ($urandom_range(0, 3) == 0));
                else
                    it = mk_item(ACT_ACK, srtt, rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom));
            end
            send_request(it);
        end
        if ($urandom_range(0, 9) < 7)
            send_request(mk_item(ACT_ACK, srtt, rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom)));
    endtask

    initial
    begin
        sb                    = new();
        sent                  = 0;
        cfg_writes            = 0;
        cycle_count           = 0;
        tx_quiet              = 1'b0;
        rx_quiet              = 1'b0;
        rx_hold               = 1'b0;
        hold_req              = 1'b0;
        rst_n                 = 1'b0;
        in_valid              = 1'b0;
        action                = ACT_RTO_DELAY;
        srtt_us               = '0;
        rtt_variance_us       = '0;
        unacked_count         = '0;
        handshake_unacked     = 1'b0;
        loss_scan_due         = 1'b0;
        cfg_valid             = 1'b0;
        peer_ack_delay_max_us = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, every action, each mode of the timeout path
        write_ack_delay(24'd0);
        send_request(mk_item(ACT_ACK, 0, 0, 0, 0, 0));
        send_request(mk_item(ACT_RTO_DELAY, 0, 0, 0, 0, 0));
        send_request(mk_item(ACT_RTO_DELAY, 1, 0, 1, 0, 0));
        send_request(mk_item(ACT_RTO_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1));
        send_request(mk_item(ACT_PROBE_DELAY, 0, 0, 0, 0, 0));
        send_request(mk_item(ACT_PROBE_DELAY, 1000, 0, 2, 0, 0));
        send_request(mk_item(ACT_PROBE_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1));
        send_request(mk_item(ACT_PROBE_DELAY, 40000, 0, 1, 0, 0));
        send_request(mk_item(ACT_HS_DELAY, 0, 0, 0, 0, 0));
        send_request(mk_item(ACT_HS_DELAY, 1, 0, 0, 0, 0));
        send_request(mk_item(ACT_HS_DELAY, 32'hFFFF_FFFF, 0, 0, 1, 1));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 0, 1, 1));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 1, 1, 1));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 5, 0, 1));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 16'hFFFF, 0, 0));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 3, 0, 0));
        send_request(mk_item(ACT_TIMEOUT, 50000, 0, 3, 0, 0));
        send_request(mk_item(ACT_RTO_DELAY, 100000, 50000, 3, 0, 0));
        send_request(mk_item(ACT_HS_DELAY, 20000, 0, 3, 0, 0));
        send_request(mk_item(ACT_SPARE_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1));
        send_request(mk_item(ACT_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1));
        send_request(mk_item(ACT_SPARE_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1));
        send_request(mk_item(ACT_ACK, 0, 0, 0, 0, 0));
        send_request(mk_item(ACT_RTO_DELAY, 0, 0, 0, 0, 0));
        drain_results();

        write_ack_delay(24'hFF_FFFF);
        while (sent < 180)
            run_episode(1'b0);
        drain_results();

        // counters driven into saturation, with the result side held off at the start of the run
        write_ack_delay(24'($urandom_range(0, 24'hFF_FFFF)));
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_req = 1'b1;
        send_request(mk_item(ACT_ACK, 0, 0, 0, 0, 0));
        for (int i = 0; i < 270; i++)
        begin
            send_request(mk_item(ACT_TIMEOUT, rand_srtt(), rand_rttvar(),
                                 16'($urandom_range(1, 65535)), 0, 0));
            if (i % 16 == 15)
                send_request(mk_item(ACT_RTO_DELAY, rand_srtt(), rand_rttvar(),
                                     rand_unacked(), 0, 0));
            if (i == 40)
                tx_quiet = 1'b0;
        end
        for (int i = 0; i < 262; i++)
        begin
            send_request(mk_item(ACT_HS_DELAY, rand_srtt(), rand_rttvar(), rand_unacked(),
                                 1'($urandom), 1'($urandom)));
            if (i % 32 == 31)
                send_request(mk_item(ACT_PROBE_DELAY, rand_srtt(), rand_rttvar(),
                                     rand_unacked(), 0, 0));
        end
        drain_results();

        write_ack_delay(24'd1);
        while (sent < 860)
            run_episode(1'b1);
        drain_results();

        write_ack_delay(24'($urandom_range(0, 50000)));
        while (sent < 950)
            run_episode($urandom_range(0, 1));
        drain_results();
        repeat (8) @(posedge clk);

        $display("run: %0d requests sent, %0d results checked, %0d ack delay settings",
                 sent, sb.checked, cfg_writes);
        $display("rto backoff saturated %0d, handshake retries saturated %0d, failures %0d",
                 sb.rto_saturated, sb.hs_saturated, sb.failures());
        if (sb.failures() == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: retransmit_timer_backoff_core.f
hw/rtl/rtb_pkg.sv
hw/rtl/rtb_delay_calc.sv
hw/rtl/rtb_backoff_state.sv
hw/rtl/retransmit_timer_backoff_core.sv
tb/sv/rtb_scoreboard_pkg.sv
tb/sv/testbench.sv
